### hw/rtl/pef_pkg.sv
package pef_pkg;

    // Field widths
    localparam int DATA_W  = 16;
    localparam int COUNT_W = 32;
    localparam int PTS_W   = 5;
    localparam int INDEX_W = 4;

    // Serial arithmetic: one bit per cycle over a 16-bit operand
    localparam int STEPS  = DATA_W;
    localparam int STEP_W = $clog2(STEPS);

    // Table depth default
    localparam int DEF_TABLE_POINTS = 16;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ENERGY     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ENERGY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLLECTION_EFF = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POINTS_IN_USE  = 2'd3;

    // Serial unit operations
    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    // Control from the sequencer to the serial unit
    typedef struct packed {
        logic start;
        logic op;
    } arith_ctl_t;

endpackage

### hw/rtl/photon_efficiency_filter.sv
// Photon efficiency filter. Takes one beat at a time on the input channel:
// a load beat (req_type 0) with an index inside the table writes one
// point of the energy/efficiency table, and a photon particle beat
// (req_type 1) is tested against the energy window and against
// random_value versus interpolated QE times collection efficiency.
// Every beat gives exactly one result beat. Load beats, non-photon
// particles and photons with fewer than two points in use go straight
// to the result; otherwise the table is scanned one point per cycle from
// the table RAM's single read port, and if a segment holds the energy a
// bit-serial unit does the interpolation multiply, the 32/16 divide and
// the collection-efficiency multiply in turn. in_stall is high while a
// beat is in work; a finished result waits in the output register
// without holding off the next input. Counters wrap at 32 bits and the
// window and efficiency loss counters may both count the same photon.
module photon_efficiency_filter #(
    parameter int TABLE_POINTS = pef_pkg::DEF_TABLE_POINTS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [pef_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pef_pkg::DATA_W-1:0]        cfg_data,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              req_type,
    input  logic [pef_pkg::INDEX_W-1:0]       point_index,
    input  logic [pef_pkg::DATA_W-1:0]        point_energy,
    input  logic [pef_pkg::DATA_W-1:0]        point_efficiency,
    input  logic                              is_photon,
    input  logic [pef_pkg::DATA_W-1:0]        photon_energy,
    input  logic [pef_pkg::DATA_W-1:0]        random_value,
    input  logic                              from_primary,
    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              kill,
    output logic                              out_of_window,
    output logic                              efficiency_reject,
    output logic [pef_pkg::DATA_W-1:0]        acceptance,
    output logic [pef_pkg::COUNT_W-1:0]       window_loss_count,
    output logic [pef_pkg::COUNT_W-1:0]       efficiency_loss_count,
    output logic [pef_pkg::COUNT_W-1:0]       primary_count,
    output logic [pef_pkg::COUNT_W-1:0]       secondary_count
);
    import pef_pkg::*;

    localparam int IDX_W = $clog2(TABLE_POINTS);
    localparam int CW    = $clog2(TABLE_POINTS + 1);
    localparam int NW    = (CW > PTS_W) ? CW : PTS_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_MUL1  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_MUL2  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // configuration registers
    logic [DATA_W-1:0]  min_reg, max_reg, ce_reg;
    logic [PTS_W-1:0]   pu_reg;

    // control
    logic [2:0]         state_reg, state_next;
    logic               start_reg, start_next;
    logic               op_reg, op_next;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] win_cnt_reg, win_cnt_next;
    logic [COUNT_W-1:0] eff_cnt_reg, eff_cnt_next;
    logic [COUNT_W-1:0] pri_cnt_reg, pri_cnt_next;
    logic [COUNT_W-1:0] sec_cnt_reg, sec_cnt_next;

    // item payload and working registers
    logic               photon_reg, photon_next;
    logic               oow_reg, oow_next;
    logic               prim_reg, prim_next;
    logic [DATA_W-1:0]  e_reg, e_next;
    logic [DATA_W-1:0]  rnd_reg, rnd_next;
    logic [IDX_W-1:0]   addr_reg, addr_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic [DATA_W-1:0]  prev_e_reg, prev_e_next;
    logic [DATA_W-1:0]  prev_q_reg, prev_q_next;
    logic               up_reg, up_next;
    logic [DATA_W-1:0]  span_reg, span_next;
    logic [DATA_W-1:0]  opa_reg, opa_next;
    logic [2*DATA_W-1:0] opb_reg, opb_next;
    logic [DATA_W-1:0]  accv_reg, accv_next;
    logic               kill_reg, kill_next;
    logic               oow_out_reg, oow_out_next;
    logic               rej_out_reg, rej_out_next;
    logic [DATA_W-1:0]  acc_out_reg, acc_out_next;

    logic               in_acc;
    logic               out_free;
    logic [NW-1:0]      pu_ext;
    logic [NW-1:0]      n_use;
    logic [NW-1:0]      idx_ext;
    logic               load_we;
    logic [2*DATA_W-1:0] ram_rdata;
    logic [DATA_W-1:0]  ram_e, ram_q;
    logic               seg_hit;
    logic               scan_last;
    logic [DATA_W-1:0]  qe;
    logic               rej_now;
    logic               commit;
    arith_ctl_t         arith_ctl;
    logic               arith_done;
    logic [2*DATA_W-1:0] arith_result;

    // handshake
    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // points in use, clamped to the table depth
    assign pu_ext = NW'(pu_reg);
    assign n_use  = (pu_ext > NW'(TABLE_POINTS)) ? NW'(TABLE_POINTS) : pu_ext;

    // table write on a load beat with an index inside the table
    assign idx_ext = NW'(point_index);
    assign load_we = in_acc && !req_type && (idx_ext < NW'(TABLE_POINTS));

    pef_ram #(
        .WIDTH (2 * DATA_W),
        .DEPTH (TABLE_POINTS)
    ) u_table (
        .clk   (clk),
        .we    (load_we),
        .waddr (idx_ext[IDX_W-1:0]),
        .wdata ({point_energy, point_efficiency}),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign ram_e = ram_rdata[2*DATA_W-1:DATA_W];
    assign ram_q = ram_rdata[DATA_W-1:0];

    // segment test against the previous point
    assign seg_hit   = (e_reg >= prev_e_reg) && (e_reg < ram_e);
    assign scan_last = (NW'(cur_reg) == (n_use - NW'(1)));

    // interpolated QE from the divide quotient
    assign qe = up_reg ? (prev_q_reg + arith_result[DATA_W-1:0])
                       : (prev_q_reg - arith_result[DATA_W-1:0]);

    assign arith_ctl.start = start_reg;
    assign arith_ctl.op    = op_reg;

    pef_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (arith_ctl),
        .opa    (opa_reg),
        .opb    (opb_reg),
        .done   (arith_done),
        .result (arith_result)
    );

    assign rej_now = photon_reg && (rnd_reg > accv_reg);
    assign commit  = (state_reg == S_DONE) && out_free;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        start_next     = 1'b0;
        op_next        = op_reg;
        out_valid_next = out_valid_reg;
        win_cnt_next   = win_cnt_reg;
        eff_cnt_next   = eff_cnt_reg;
        pri_cnt_next   = pri_cnt_reg;
        sec_cnt_next   = sec_cnt_reg;
        photon_next    = photon_reg;
        oow_next       = oow_reg;
        prim_next      = prim_reg;
        e_next         = e_reg;
        rnd_next       = rnd_reg;
        addr_next      = addr_reg;
        cur_next       = cur_reg;
        prev_e_next    = prev_e_reg;
        prev_q_next    = prev_q_reg;
        up_next        = up_reg;
        span_next      = span_reg;
        opa_next       = opa_reg;
        opb_next       = opb_reg;
        accv_next      = accv_reg;
        kill_next      = kill_reg;
        oow_out_next   = oow_out_reg;
        rej_out_next   = rej_out_reg;
        acc_out_next   = acc_out_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    photon_next = req_type && is_photon;
                    e_next      = photon_energy;
                    rnd_next    = random_value;
                    prim_next   = from_primary;
                    oow_next    = (photon_energy < min_reg) || (photon_energy > max_reg);
                    addr_next   = '0;
                    accv_next   = '0;
                    if (req_type && is_photon && (n_use >= NW'(2)))
                    begin
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_FETCH:
            begin
                addr_next  = addr_reg + IDX_W'(1);
                cur_next   = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                addr_next   = addr_reg + IDX_W'(1);
                cur_next    = cur_reg + IDX_W'(1);
                prev_e_next = ram_e;
                prev_q_next = ram_q;
                if ((cur_reg != '0) && seg_hit)
                begin
                    // keep q0 of the matching segment
                    prev_q_next = prev_q_reg;
                    up_next     = (ram_q >= prev_q_reg);
                    span_next   = ram_e - prev_e_reg;
                    opa_next    = (ram_q >= prev_q_reg) ? (ram_q - prev_q_reg)
                                                        : (prev_q_reg - ram_q);
                    opb_next    = {{DATA_W{1'b0}}, e_reg - prev_e_reg};
                    op_next     = OP_MUL;
                    start_next  = 1'b1;
                    state_next  = S_MUL1;
                end
                else if (scan_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_MUL1:
            begin
                if (arith_done)
                begin
                    opa_next   = span_reg;
                    opb_next   = arith_result;
                    op_next    = OP_DIV;
                    start_next = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (arith_done)
                begin
                    opa_next   = ce_reg;
                    opb_next   = {{DATA_W{1'b0}}, qe};
                    op_next    = OP_MUL;
                    start_next = 1'b1;
                    state_next = S_MUL2;
                end
            end
            S_MUL2:
            begin
                if (arith_done)
                begin
                    accv_next  = arith_result[2*DATA_W-1:DATA_W];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    kill_next      = (photon_reg && oow_reg) || rej_now;
                    oow_out_next   = photon_reg && oow_reg;
                    rej_out_next   = rej_now;
                    acc_out_next   = accv_reg;
                    out_valid_next = 1'b1;
                    if (photon_reg)
                    begin
                        if (oow_reg)
                        begin
                            win_cnt_next = win_cnt_reg + COUNT_W'(1);
                        end
                        if (rej_now)
                        begin
                            eff_cnt_next = eff_cnt_reg + COUNT_W'(1);
                        end
                        if (prim_reg)
                        begin
                            pri_cnt_next = pri_cnt_reg + COUNT_W'(1);
                        end
                        else
                        begin
                            sec_cnt_next = sec_cnt_reg + COUNT_W'(1);
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            win_cnt_reg   <= '0;
            eff_cnt_reg   <= '0;
            pri_cnt_reg   <= '0;
            sec_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
            win_cnt_reg   <= win_cnt_next;
            eff_cnt_reg   <= eff_cnt_next;
            pri_cnt_reg   <= pri_cnt_next;
            sec_cnt_reg   <= sec_cnt_next;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '0;
            max_reg <= '1;
            ce_reg  <= '1;
            pu_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_ENERGY:     min_reg <= cfg_data;
                REG_MAX_ENERGY:     max_reg <= cfg_data;
                REG_COLLECTION_EFF: ce_reg  <= cfg_data;
                REG_POINTS_IN_USE:  pu_reg  <= cfg_data[PTS_W-1:0];
                default:            pu_reg  <= pu_reg;
            endcase
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        photon_reg  <= photon_next;
        oow_reg     <= oow_next;
        prim_reg    <= prim_next;
        e_reg       <= e_next;
        rnd_reg     <= rnd_next;
        addr_reg    <= addr_next;
        cur_reg     <= cur_next;
        prev_e_reg  <= prev_e_next;
        prev_q_reg  <= prev_q_next;
        up_reg      <= up_next;
        span_reg    <= span_next;
        opa_reg     <= opa_next;
        opb_reg     <= opb_next;
        accv_reg    <= accv_next;
        kill_reg    <= kill_next;
        oow_out_reg <= oow_out_next;
        rej_out_reg <= rej_out_next;
        acc_out_reg <= acc_out_next;
    end

    // outputs
    assign out_valid             = out_valid_reg;
    assign kill                  = kill_reg;
    assign out_of_window         = oow_out_reg;
    assign efficiency_reject     = rej_out_reg;
    assign acceptance            = acc_out_reg;
    assign window_loss_count     = win_cnt_reg;
    assign efficiency_loss_count = eff_cnt_reg;
    assign primary_count         = pri_cnt_reg;
    assign secondary_count       = sec_cnt_reg;

    // Checks
    a_counters_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(win_cnt_reg) && $stable(eff_cnt_reg)
                    && $stable(pri_cnt_reg) && $stable(sec_cnt_reg))
        else $error("counter changed outside a result commit");

    a_parent_counted_once: assert property (@(posedge clk) disable iff (!rst_n)
        commit && photon_reg |=> ((pri_cnt_reg != $past(pri_cnt_reg))
                                  != (sec_cnt_reg != $past(sec_cnt_reg))))
        else $error("photon parent not counted exactly once");

    a_kill_from_causes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (kill_reg == (oow_out_reg || rej_out_reg)))
        else $error("kill does not match its causes");

    a_arith_only_in_math: assert property (@(posedge clk) disable iff (!rst_n)
        arith_done |-> (state_reg == S_MUL1) || (state_reg == S_DIV)
                       || (state_reg == S_MUL2))
        else $error("serial unit finished outside an arithmetic phase");

endmodule

### hw/rtl/pef_ram.sv
module pef_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/pef_arith.sv
// Bit-serial 16x16 shift-add multiplier and 32/16 restoring divider
// sharing one 32-bit working register. The divide assumes the quotient
// fits in 16 bits (upper half of the dividend below the divisor).
module pef_arith (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pef_pkg::arith_ctl_t               ctl,
    input  logic [pef_pkg::DATA_W-1:0]        opa,
    input  logic [2*pef_pkg::DATA_W-1:0]      opb,
    output logic                              done,
    output logic [2*pef_pkg::DATA_W-1:0]      result
);
    import pef_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  op_reg, op_next;
    logic [STEP_W-1:0]     cnt_reg, cnt_next;
    logic [2*DATA_W-1:0]   acc_reg, acc_next;

    logic [DATA_W:0]       mul_sum;
    logic [DATA_W:0]       div_trial;
    logic                  div_ge;
    logic [DATA_W:0]       div_diff;

    // One multiply step: add multiplicand on the low bit, shift right
    assign mul_sum = {1'b0, acc_reg[2*DATA_W-1:DATA_W]}
                   + (acc_reg[0] ? {1'b0, opa} : '0);

    // One divide step: shift in next dividend bit, trial subtract
    assign div_trial = {acc_reg[2*DATA_W-1:DATA_W], acc_reg[DATA_W-1]};
    assign div_ge    = (div_trial >= {1'b0, opa});
    assign div_diff  = div_trial - {1'b0, opa};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            op_next   = ctl.op;
            cnt_next  = '0;
            acc_next  = opb;
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_DIV)
            begin
                acc_next = {(div_ge ? div_diff[DATA_W-1:0] : div_trial[DATA_W-1:0]),
                            acc_reg[DATA_W-2:0], div_ge};
            end
            else
            begin
                acc_next = {mul_sum, acc_reg[DATA_W-1:1]};
            end
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == STEP_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

    // Checks
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.start |-> !busy_reg)
        else $error("serial unit started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("done without a running operation");

    a_busy_ends_in_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !ctl.start && cnt_reg == STEP_W'(STEPS - 1) |=> done_reg)
        else $error("last step did not raise done");

endmodule
